// ===== rtl/core/arpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP address cache
// Field widths, result status codes, operation codes and the command and
// status groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int KEY_W  = 32;
    localparam int MAC_W  = 48;
    localparam int FILL_W = 7;
    localparam int STAT_W = 3;

    // operation codes carried by the cmd field
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_DROPPED  = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word, restart scan
        logic scan_step;  // one step of the table scan
        logic commit;     // apply add or resolve lookup, set status
        logic mac_rd;     // read MAC of the matching entry
        logic out_load;   // move result into the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic lookup;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/arp_address_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_address_cache: IPv4-to-MAC binding table
// Add words update or append a binding; lookup words return the stored MAC.
// ----------------------------------------------------------------------------
// One word is handled at a time. After acceptance the key table is scanned
// one entry per cycle through its single read port. Each word passes
// through acceptance, the pipelined scan, a commit step, a MAC read on a
// lookup hit only, and the load of the result into the output register.
// A match ends the scan early. A stalled result holds the next acceptance
// back for as long as it waits. The next word is accepted as soon as the
// result sits in the output register. An add to a full table with a new
// IP is dropped and reported with the dropped status. There is no
// eviction; table contents after reset are unknown but never read, since
// only entries below the fill count are scanned.
module arp_address_cache #(
    parameter int ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [arpc_pkg::KEY_W-1:0]    s_ip_key,
    input  logic [arpc_pkg::MAC_W-1:0]    s_mac_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [arpc_pkg::STAT_W-1:0]   m_status,
    output logic [arpc_pkg::MAC_W-1:0]    m_mac_out,
    output logic [arpc_pkg::FILL_W-1:0]   m_fill_count
);

    arpc_pkg::ctrl_cmd_t ctl_cmd;
    arpc_pkg::ctrl_sts_t ctl_sts;

    // sequencing
    arpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (ctl_sts),
        .cmd     (ctl_cmd)
    );

    // tables, scan and output register
    arpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (ctl_cmd),
        .sts          (ctl_sts),
        .s_cmd        (s_cmd),
        .s_ip_key     (s_ip_key),
        .s_mac_in     (s_mac_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_mac_out    (m_mac_out),
        .m_fill_count (m_fill_count)
    );

endmodule

// ===== rtl/core/arpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data that holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl: sequencing state machine of the ARP address cache
// Walks each word through accept, table scan, commit, optional MAC read
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  arpc_pkg::ctrl_sts_t sts,
    output arpc_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_MREAD  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.commit = 1'b1;
                if (sts.lookup && sts.found) begin
                    state_next = S_MREAD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MREAD: begin
                cmd.mac_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    // checks
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register occupied");

    a_commit_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (state_reg == S_MREAD || state_reg == S_FINISH))
        else $error("commit not followed by MAC read or finish");

endmodule

// ===== rtl/core/arpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_dp: datapath of the ARP address cache
// Holds the key and MAC tables, the fill count, the scan pointer and the
// output register. Scans the key table one entry per cycle.
// ----------------------------------------------------------------------------
module arpc_dp #(
    parameter int ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  arpc_pkg::ctrl_cmd_t           cmd,
    output arpc_pkg::ctrl_sts_t           sts,
    input  logic                          s_cmd,
    input  logic [arpc_pkg::KEY_W-1:0]    s_ip_key,
    input  logic [arpc_pkg::MAC_W-1:0]    s_mac_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [arpc_pkg::STAT_W-1:0]   m_status,
    output logic [arpc_pkg::MAC_W-1:0]    m_mac_out,
    output logic [arpc_pkg::FILL_W-1:0]   m_fill_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = (CNT_W > arpc_pkg::FILL_W) ? CNT_W : arpc_pkg::FILL_W;

    // captured word
    logic                       cmd_reg;
    logic [arpc_pkg::KEY_W-1:0] key_reg;
    logic [arpc_pkg::MAC_W-1:0] mac_reg;

    // table and scan state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    arpc_pkg::status_t st_reg;

    // output register
    logic                         m_valid_reg;
    logic [arpc_pkg::STAT_W-1:0]  m_status_reg;
    logic [arpc_pkg::MAC_W-1:0]   m_mac_reg;
    logic [arpc_pkg::FILL_W-1:0]  m_fill_reg;

    // memory ports
    logic                       key_we, mac_we, key_re, mac_re;
    logic [IDX_W-1:0]           mac_waddr;
    logic [arpc_pkg::KEY_W-1:0] key_rdata;
    logic [arpc_pkg::MAC_W-1:0] mac_rdata;

    logic             issue, match, full, is_lookup, do_insert;
    logic [EXT_W-1:0] count_ext;

    // scan control
    assign issue     = cmd.scan_step && !found_reg && (rd_idx_reg != count_reg);
    assign match     = cmd.scan_step && pend_reg && !found_reg && (key_rdata == key_reg);
    assign full      = (count_reg == CNT_W'(ENTRIES));
    assign is_lookup = (cmd_reg == arpc_pkg::CMD_LOOKUP);
    assign do_insert = cmd.commit && !is_lookup && !found_reg && !full;

    // table writes
    assign key_we    = do_insert;
    assign mac_we    = cmd.commit && !is_lookup && (found_reg || !full);
    assign mac_waddr = found_reg ? hit_idx_reg : count_reg[IDX_W-1:0];
    assign key_re    = issue;
    assign mac_re    = cmd.mac_rd;

    arpc_ram #(
        .WIDTH (arpc_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .re    (key_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    arpc_ram #(
        .WIDTH (arpc_pkg::MAC_W),
        .DEPTH (ENTRIES)
    ) u_mac_ram (
        .aclk  (aclk),
        .we    (mac_we),
        .waddr (mac_waddr),
        .wdata (mac_reg),
        .re    (mac_re),
        .raddr (hit_idx_reg),
        .rdata (mac_rdata)
    );

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_cmd;
            key_reg <= s_ip_key;
            mac_reg <= s_mac_in;
        end
    end

    // scan pointer, compare stage, fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                found_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                pend_reg <= issue;
                if (issue) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (match) begin
                    found_reg <= 1'b1;
                end
            end
            if (do_insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // index bookkeeping for the compare stage
    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (match) begin
            hit_idx_reg <= pend_idx_reg;
        end
    end

    // result status
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (is_lookup) begin
                st_reg <= found_reg ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
            end else if (found_reg) begin
                st_reg <= arpc_pkg::ST_UPDATED;
            end else if (!full) begin
                st_reg <= arpc_pkg::ST_INSERTED;
            end else begin
                st_reg <= arpc_pkg::ST_DROPPED;
            end
        end
    end

    // output register
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= st_reg;
            m_mac_reg    <= (st_reg == arpc_pkg::ST_HIT) ? mac_rdata : '0;
            m_fill_reg   <= count_ext[arpc_pkg::FILL_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_mac_out    = m_mac_reg;
    assign m_fill_count = m_fill_reg;

    // status to controller
    assign sts.scan_done = found_reg || (!pend_reg && (rd_idx_reg == count_reg));
    assign sts.found     = found_reg;
    assign sts.lookup    = is_lookup;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // checks
    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (CNT_W'(hit_idx_reg) < count_reg))
        else $error("match index beyond fill count");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_idx_reg <= count_reg) && (count_reg <= CNT_W'(ENTRIES)))
        else $error("scan pointer or fill count out of range");

    a_count_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(count_reg))
        else $error("fill count changed outside commit");

endmodule
